// ===== rtl/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants of the serial frame builder with CRC-7.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int OP_W          = 8;
    localparam int LEN_IN_W      = 3;
    localparam int PAYLOAD_W     = 32;
    localparam int BYTE_W        = 8;
    localparam int CRC_W         = 7;

    localparam int MAX_PAYLOAD_DEFAULT = 4;
    localparam int MAX_PAYLOAD_LIMIT   = 8;
    localparam int WIDE_PAYLOAD_W      = MAX_PAYLOAD_LIMIT * BYTE_W;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h23;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h53;
    localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h89;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYNC2,
        ST_OP,
        ST_LEN,
        ST_PAY,
        ST_CRC
    } t_state;

    typedef enum logic [1:0] {
        CRC_SRC_NONE,
        CRC_SRC_OP,
        CRC_SRC_LEN,
        CRC_SRC_PAY
    } t_crc_src;

endpackage

// ===== rtl/sfb_if.sv =====
// ----------------------------------------------------------------------------
// sfb_if
// Valid/ready channels of the frame builder: request in, frame bytes out.
// ----------------------------------------------------------------------------
interface sfb_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [sfb_pkg::OP_W-1:0]             operation;
    logic [sfb_pkg::LEN_IN_W-1:0]         payload_len;
    logic [sfb_pkg::PAYLOAD_W-1:0]        payload;

    modport source (output valid, output operation, output payload_len, output payload,
                    input ready);
    modport sink   (input valid, input operation, input payload_len, input payload,
                    output ready);
endinterface

interface sfb_byte_if;
    logic                        valid;
    logic                        ready;
    logic [sfb_pkg::BYTE_W-1:0]  frame_byte;
    logic                        last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

// ===== rtl/sfb_crc7_unit.sv =====
// ----------------------------------------------------------------------------
// sfb_crc7_unit
// Byte-wide CRC-7 update (x^7+x^3+1, MSB first), shared by the operation, length and payload bytes.
// ----------------------------------------------------------------------------
module sfb_crc7_unit (
    input  logic [sfb_pkg::CRC_W-1:0]  i_crc,
    input  logic [sfb_pkg::BYTE_W-1:0] i_byte,
    output logic [sfb_pkg::CRC_W-1:0]  o_crc
);

    always_comb begin
        logic [sfb_pkg::CRC_W-1:0] c;
        logic                      fb;
        c = i_crc;
        for (int b = sfb_pkg::BYTE_W - 1; b >= 0; b--) begin
            fb = c[sfb_pkg::CRC_W-1] ^ i_byte[b];
            c  = {c[sfb_pkg::CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ sfb_pkg::CRC_POLY[sfb_pkg::CRC_W-1:0];
            end
        end
        o_crc = c;
    end

endmodule

// ===== rtl/serial_frame_builder_crc7.sv =====
// ----------------------------------------------------------------------------
// serial_frame_builder_crc7
// Builds a framed message with a CRC-7 check byte, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one message request (operation, payload_len, payload).
//   o_frm carries the frame bytes: '#', 'S', operation, length, then the
//   payload bytes least significant first, then the CRC-7 byte with last=1.
//   A payload_len above MAX_PAYLOAD_BYTES is saturated to it; payload bytes
//   above bit 31 go out as zero.
// Timing:
//   The request transfer loads the first sync byte into the output register,
//   so it appears on o_frm the next cycle. One byte is loaded per cycle while
//   the output register is free or being taken. i_req.ready is high only when
//   the sequencer is idle and the output register is free, so a new request
//   is taken only after the CRC byte is loaded. A single byte-wide CRC unit
//   serves every covered byte.
// Reset and stall:
//   Reset (i_rst_n low, synchronous) drops any frame in progress and empties
//   the output register. A stalled o_frm holds the byte and the sequencer.
// ----------------------------------------------------------------------------
module serial_frame_builder_crc7 #(
    parameter int MAX_PAYLOAD_BYTES = sfb_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sfb_req_if.sink           i_req,
    sfb_byte_if.source        o_frm
);

    localparam int PAY_W = MAX_PAYLOAD_BYTES * sfb_pkg::BYTE_W;
    localparam int LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);

    // sequencer state and latched request
    sfb_pkg::t_state            r_state, n_state;
    logic [sfb_pkg::OP_W-1:0]   r_op;
    logic [LEN_W-1:0]           r_len;
    logic [PAY_W-1:0]           r_pay;
    logic [sfb_pkg::CRC_W-1:0]  r_crc;

    // output register
    logic                       r_out_valid;
    logic [sfb_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_last;

    logic                       slot_free;
    logic                       emit;
    logic [sfb_pkg::BYTE_W-1:0] emit_byte;
    logic                       emit_last;
    sfb_pkg::t_crc_src          crc_src;
    logic [sfb_pkg::CRC_W-1:0]  crc_in;
    logic [sfb_pkg::BYTE_W-1:0] crc_byte;
    logic [sfb_pkg::CRC_W-1:0]  crc_out;
    logic [LEN_W-1:0]           sat_len;
    logic [sfb_pkg::WIDE_PAYLOAD_W-1:0] wide_pay;
    logic                       accept;

    // the output register can take a byte when empty or being drained
    assign slot_free   = !r_out_valid || o_frm.ready;
    assign i_req.ready = (r_state == sfb_pkg::ST_IDLE) && slot_free;
    assign accept      = i_req.valid && i_req.ready;

    // saturate the length to the configured payload limit
    assign sat_len = (int'(i_req.payload_len) > MAX_PAYLOAD_BYTES)
                   ? LEN_W'(MAX_PAYLOAD_BYTES) : LEN_W'(i_req.payload_len);
    // zero-extend the payload word so bytes past bit 31 read as zero
    assign wide_pay = sfb_pkg::WIDE_PAYLOAD_W'(i_req.payload);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfb_pkg::ST_IDLE: begin
                if (accept) n_state = sfb_pkg::ST_SYNC2;
            end
            sfb_pkg::ST_SYNC2: begin
                if (slot_free) n_state = sfb_pkg::ST_OP;
            end
            sfb_pkg::ST_OP: begin
                if (slot_free) n_state = sfb_pkg::ST_LEN;
            end
            sfb_pkg::ST_LEN: begin
                if (slot_free) begin
                    n_state = (r_len == '0) ? sfb_pkg::ST_CRC : sfb_pkg::ST_PAY;
                end
            end
            sfb_pkg::ST_PAY: begin
                if (slot_free && r_len == LEN_W'(1)) n_state = sfb_pkg::ST_CRC;
            end
            sfb_pkg::ST_CRC: begin
                if (slot_free) n_state = sfb_pkg::ST_IDLE;
            end
            default: n_state = sfb_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: byte to emit and CRC unit operand select
    always_comb begin
        emit      = 1'b0;
        emit_byte = '0;
        emit_last = 1'b0;
        crc_src   = sfb_pkg::CRC_SRC_NONE;
        case (r_state)
            sfb_pkg::ST_IDLE: begin
                emit      = accept;
                emit_byte = sfb_pkg::SYNC_FIRST;
            end
            sfb_pkg::ST_SYNC2: begin
                emit      = slot_free;
                emit_byte = sfb_pkg::SYNC_SECOND;
            end
            sfb_pkg::ST_OP: begin
                emit      = slot_free;
                emit_byte = r_op;
                crc_src   = sfb_pkg::CRC_SRC_OP;
            end
            sfb_pkg::ST_LEN: begin
                emit      = slot_free;
                emit_byte = sfb_pkg::BYTE_W'(r_len);
                crc_src   = sfb_pkg::CRC_SRC_LEN;
            end
            sfb_pkg::ST_PAY: begin
                emit      = slot_free;
                emit_byte = r_pay[sfb_pkg::BYTE_W-1:0];
                crc_src   = sfb_pkg::CRC_SRC_PAY;
            end
            sfb_pkg::ST_CRC: begin
                emit      = slot_free;
                emit_byte = sfb_pkg::BYTE_W'(r_crc);
                emit_last = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // operands of the shared CRC unit; the operation byte starts from zero
    always_comb begin
        crc_in   = r_crc;
        crc_byte = '0;
        case (crc_src)
            sfb_pkg::CRC_SRC_OP: begin
                crc_in   = '0;
                crc_byte = r_op;
            end
            sfb_pkg::CRC_SRC_LEN: crc_byte = sfb_pkg::BYTE_W'(r_len);
            sfb_pkg::CRC_SRC_PAY: crc_byte = r_pay[sfb_pkg::BYTE_W-1:0];
            default:              crc_byte = '0;
        endcase
    end

    sfb_crc7_unit u_crc (
        .i_crc  (crc_in),
        .i_byte (crc_byte),
        .o_crc  (crc_out)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_frm.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: latch the request, advance the payload shifter, update the CRC and output byte
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.operation;
            r_len <= sat_len;
            r_pay <= wide_pay[PAY_W-1:0];
        end else if (r_state == sfb_pkg::ST_PAY && slot_free) begin
            r_len <= r_len - LEN_W'(1);
            r_pay <= r_pay >> sfb_pkg::BYTE_W;
        end
        if (emit && crc_src != sfb_pkg::CRC_SRC_NONE) begin
            r_crc <= crc_out;
        end
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
        end
    end

    assign o_frm.valid      = r_out_valid;
    assign o_frm.frame_byte = r_out_byte;
    assign o_frm.last       = r_out_last;

endmodule

// ===== tb/sv/serial_frame_builder_crc7_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_builder_crc7_checker
// Watches the request and byte channels, predicts each frame with its CRC-7
// and compares every byte transfer against the oldest predicted byte.
// ----------------------------------------------------------------------------
module serial_frame_builder_crc7_checker #(
    parameter int PAYLOAD_CAP = sfb_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sfb_req_if    i_req,
    sfb_byte_if   i_frm,
    output int    o_fail_count,
    output int    o_bytes_due
);

    typedef struct packed {
        logic [sfb_pkg::BYTE_W-1:0] value;
        logic                       last;
    } t_frame_slot;

    t_frame_slot frame_bytes_due[$];
    t_frame_slot oldest;
    int          mismatches = 0;
    int          due_count  = 0;

    assign o_fail_count = mismatches;
    assign o_bytes_due  = due_count;

    // Shift one byte through the CRC-7 register, MSB first, x^7 + x^3 + 1.
    function automatic logic [sfb_pkg::CRC_W-1:0] crc7_fold(
        input logic [sfb_pkg::CRC_W-1:0]  crc,
        input logic [sfb_pkg::BYTE_W-1:0] data);
        logic [sfb_pkg::CRC_W-1:0] acc;
        logic                      fb;
        acc = crc;
        for (int b = sfb_pkg::BYTE_W - 1; b >= 0; b--) begin
            fb  = acc[sfb_pkg::CRC_W-1] ^ data[b];
            acc = {acc[sfb_pkg::CRC_W-2:0], 1'b0};
            if (fb) begin
                acc = acc ^ sfb_pkg::CRC_POLY[sfb_pkg::CRC_W-1:0];
            end
        end
        return acc;
    endfunction

    function automatic void queue_frame(input logic [sfb_pkg::OP_W-1:0]      op,
                                        input logic [sfb_pkg::LEN_IN_W-1:0]  len_req,
                                        input logic [sfb_pkg::PAYLOAD_W-1:0] word);
        int                         n;
        logic [sfb_pkg::BYTE_W-1:0] len_byte;
        logic [sfb_pkg::BYTE_W-1:0] pay_byte;
        logic [sfb_pkg::CRC_W-1:0]  crc;
        n        = (int'(len_req) > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(len_req);
        len_byte = sfb_pkg::BYTE_W'(n);
        frame_bytes_due.push_back('{sfb_pkg::SYNC_FIRST, 1'b0});
        frame_bytes_due.push_back('{sfb_pkg::SYNC_SECOND, 1'b0});
        frame_bytes_due.push_back('{op, 1'b0});
        frame_bytes_due.push_back('{len_byte, 1'b0});
        crc = crc7_fold(crc7_fold('0, op), len_byte);
        for (int i = 0; i < n; i++) begin
            // bytes above the 32-bit word go out as zero
            pay_byte = (i < sfb_pkg::PAYLOAD_W / sfb_pkg::BYTE_W)
                     ? word[sfb_pkg::BYTE_W*i +: sfb_pkg::BYTE_W] : '0;
            frame_bytes_due.push_back('{pay_byte, 1'b0});
            crc = crc7_fold(crc, pay_byte);
        end
        frame_bytes_due.push_back('{{1'b0, crc}, 1'b1});
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [sfb_pkg::BYTE_W-1:0] got,
                                   input logic [sfb_pkg::BYTE_W-1:0] want);
        $display("checker: %0t %s: got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                queue_frame(i_req.operation, i_req.payload_len, i_req.payload);
            end
            if (i_frm.valid === 1'b1 && i_frm.ready === 1'b1) begin
                if (frame_bytes_due.size() == 0) begin
                    report_mismatch("byte with no frame due", i_frm.frame_byte, '0);
                end else begin
                    oldest = frame_bytes_due.pop_front();
                    if (i_frm.frame_byte !== oldest.value) begin
                        report_mismatch("frame_byte", i_frm.frame_byte, oldest.value);
                    end
                    if (i_frm.last !== oldest.last) begin
                        report_mismatch("last", sfb_pkg::BYTE_W'(i_frm.last),
                                        sfb_pkg::BYTE_W'(oldest.last));
                    end
                end
            end
        end
        due_count = frame_bytes_due.size();
    end

endmodule

// ===== tb/sv/serial_frame_builder_crc7_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_builder_crc7_tb
// Drives message requests into the frame builder and stalls its byte output
// at random; the checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module serial_frame_builder_crc7_tb;

    localparam int RANDOM_ITEMS   = 400;
    localparam int GAP_PCT        = 13;
    localparam int CALM_FROM      = 120;   // random items with no gaps on either side
    localparam int CALM_TO        = 200;
    localparam int BACKLOG_AT     = 300;   // receiver hold-off starts once this many are offered
    localparam int BACKLOG_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 300000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sfb_req_if  req_ch ();
    sfb_byte_if frm_ch ();

    int fail_count;
    int bytes_due;
    int cycles        = 0;
    int items_offered = 0;
    bit calm_stretch  = 1'b0;

    serial_frame_builder_crc7 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_frm   (frm_ch)
    );

    serial_frame_builder_crc7_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_frm        (frm_ch),
        .o_fail_count (fail_count),
        .o_bytes_due  (bytes_due)
    );

    always #1 i_clk = ~i_clk;

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Roll for an idle cycle; none while the calm stretch is on.
    function automatic bit take_gap();
        return !calm_stretch && ($urandom_range(99) < GAP_PCT);
    endfunction

    // Offer one request and hold it until the block takes it. Called just after
    // a falling edge; returns just after the falling edge that follows the transfer.
    task automatic send_request(input logic [sfb_pkg::OP_W-1:0]      op,
                                input logic [sfb_pkg::LEN_IN_W-1:0]  len,
                                input logic [sfb_pkg::PAYLOAD_W-1:0] pay);
        while (take_gap()) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.payload_len <= len;
        req_ch.payload     <= pay;
        items_offered++;
        do begin
            @(posedge i_clk);
        end while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Receiver side: random stalls, plus one long hold-off so the output
    // register fills and the block has to refuse new requests.
    initial begin : byte_sink
        int  hold_left;
        bit  backlog_done;
        hold_left    = 0;
        backlog_done = 1'b0;
        frm_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!backlog_done && items_offered >= BACKLOG_AT) begin
                backlog_done = 1'b1;
                hold_left    = BACKLOG_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                frm_ch.ready <= 1'b0;
            end else begin
                frm_ch.ready <= !take_gap();
            end
        end
    end

    initial begin : request_source
        req_ch.valid       = 1'b0;
        req_ch.operation   = '0;
        req_ch.payload_len = '0;
        req_ch.payload     = '0;

        // Hold reset, then release it on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty payload, field extremes, every length including the
        // saturated ones, alternating bit patterns, sync-like payload bytes.
        send_request(8'h00, 3'd0, 32'h0000_0000);
        send_request(8'hFF, 3'd0, 32'hFFFF_FFFF);
        send_request(8'h00, 3'd4, 32'h0000_0000);
        send_request(8'hFF, 3'd4, 32'hFFFF_FFFF);
        send_request(8'hA5, 3'd1, 32'h0000_00C3);
        send_request(8'h5A, 3'd2, 32'h1234_5678);
        send_request(8'h3C, 3'd3, 32'h89AB_CDEF);
        send_request(8'hC3, 3'd4, 32'hAAAA_AAAA);
        send_request(8'h81, 3'd4, 32'h5555_5555);
        send_request(8'h01, 3'd5, 32'hFFFF_FFFF);
        send_request(8'h02, 3'd6, 32'h0102_0304);
        send_request(8'hFE, 3'd7, 32'hDEAD_BEEF);
        send_request(8'h23, 3'd2, 32'h0000_5323);
        send_request(8'h80, 3'd4, 32'h8080_8080);
        send_request(8'h7F, 3'd4, 32'h7F7F_7F7F);
        send_request(8'h89, 3'd1, 32'hFFFF_FF89);

        // Random: any length 0..7, so saturation shows up often.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm_stretch = (n >= CALM_FROM && n < CALM_TO);
            send_request(sfb_pkg::OP_W'($urandom_range(255)),
                         sfb_pkg::LEN_IN_W'($urandom_range(7)),
                         $urandom());
        end
        calm_stretch = 1'b0;
        req_ch.valid <= 1'b0;

        // Drain every predicted byte, then let the pipeline settle.
        while (bytes_due != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== serial_frame_builder_crc7.f =====
rtl/sfb_pkg.sv
rtl/sfb_if.sv
rtl/sfb_crc7_unit.sv
rtl/serial_frame_builder_crc7.sv
tb/sv/serial_frame_builder_crc7_checker.sv
tb/sv/serial_frame_builder_crc7_tb.sv
